### design/cpt_pkg.sv
// shared types, constants and the quarter-wave sine table for the coordinate transform
// no dependencies; every other file in design/ refers to this package by scoped names
package cpt_pkg;

   localparam int DATA_WIDTH      = 16;
   localparam int SINE_TABLE_BITS = 10;
   localparam int QUARTER         = 2 ** (SINE_TABLE_BITS - 2);

   // Q1.15 sine amplitude and fraction bits
   localparam int FRAC_BITS  = 15;
   localparam int SIN_MAG_W  = 15;
   localparam int SIN_W      = SIN_MAG_W + 1;

   localparam int PROD_W        = DATA_WIDTH + SIN_W;
   localparam int SUM_W         = PROD_W + 1;
   localparam int CLARKE_SUM_W  = DATA_WIDTH + 2;
   localparam int INV_SQRT3_W   = 16;
   localparam int CLARKE_PROD_W = CLARKE_SUM_W + INV_SQRT3_W + 1;
   localparam int CLARKE_SHIFT  = 16;
   localparam int WIDE_W        = CLARKE_PROD_W;

   localparam logic [INV_SQRT3_W-1:0] INV_SQRT3_Q16 = 16'd37837;

   localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'((2 ** (DATA_WIDTH - 1)) - 1);
   localparam logic signed [WIDE_W-1:0] SAT_LO = -WIDE_W'(2 ** (DATA_WIDTH - 1));

   // table generation constants, used at elaboration only
   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] SIN_AMP = 64'd32767;
   localparam int HORNER_STEPS = 7;
   localparam int HORNER_DIV [HORNER_STEPS] = '{210, 156, 110, 72, 42, 20, 6};

   typedef enum logic [1:0] {
      FUNC_CLARKE   = 2'd0,
      FUNC_PARK     = 2'd1,
      FUNC_INV_PARK = 2'd2
   } func_type;

   typedef logic [SIN_MAG_W-1:0] sin_table_type [QUARTER];

   typedef struct packed {
      logic [1:0]                   func;
      logic signed [DATA_WIDTH-1:0] a;
      logic signed [DATA_WIDTH-1:0] b;
      logic [SINE_TABLE_BITS-1:0]   k;
   } in_stage_type;

   typedef struct packed {
      logic [1:0]                   func;
      logic signed [DATA_WIDTH-1:0] a;
      logic signed [DATA_WIDTH-1:0] b;
      logic signed [SIN_W-1:0]      sin;
      logic signed [SIN_W-1:0]      cos;
   } lookup_stage_type;

   typedef struct packed {
      logic [1:0]                      func;
      logic signed [DATA_WIDTH-1:0]    a;
      logic signed [PROD_W-1:0]        a_c;
      logic signed [PROD_W-1:0]        b_s;
      logic signed [PROD_W-1:0]        b_c;
      logic signed [PROD_W-1:0]        a_s;
      logic signed [CLARKE_PROD_W-1:0] clarke;
   } prod_stage_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] out_a;
      logic signed [DATA_WIDTH-1:0] out_b;
      logic                         saturated;
   } rsp_stage_type;

   typedef struct packed {
      logic                         clipped;
      logic signed [DATA_WIDTH-1:0] value;
   } sat_type;

   // taylor series sine of quarter-wave point j, horner form in Q2.30
   function automatic logic [63:0] qsin15(input logic [63:0] j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = (PI_Q30 * j) >> (SINE_TABLE_BITS - 1);
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int i = 0; i < HORNER_STEPS; i++) begin
         t = ONE_Q30 - (((x2 * t) >> 30) / HORNER_DIV[i]);
      end
      s = (x * t) >> 30;
      s = (s * SIN_AMP + (64'd1 << 29)) >> 30;
      if (s > SIN_AMP) begin
         s = SIN_AMP;
      end
      return s;
   endfunction

   function automatic sin_table_type build_sin_table();
      sin_table_type tbl;
      for (int j = 0; j < QUARTER; j++) begin
         tbl[j] = SIN_MAG_W'(qsin15(64'(j)));
      end
      return tbl;
   endfunction

   localparam sin_table_type SIN_TABLE = build_sin_table();
   localparam logic [SIN_MAG_W-1:0] SIN_PEAK = SIN_MAG_W'(qsin15(64'(QUARTER)));

   function automatic sat_type saturate(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      if (v > SAT_HI) begin
         r.clipped = 1'b1;
         r.value   = DATA_WIDTH'(SAT_HI);
      end else if (v < SAT_LO) begin
         r.clipped = 1'b1;
         r.value   = DATA_WIDTH'(SAT_LO);
      end else begin
         r.clipped = 1'b0;
         r.value   = DATA_WIDTH'(v);
      end
      return r;
   endfunction

endpackage

### design/cpt_sine_lookup.sv
// signed Q1.15 sine of a full-turn table index, built from the quarter-wave table
// depends on cpt_pkg
module cpt_sine_lookup (
   input  logic [cpt_pkg::SINE_TABLE_BITS-1:0]   k,
   output logic signed [cpt_pkg::SIN_W-1:0]      sin
);

   logic [1:0]                              quad;
   logic [cpt_pkg::SINE_TABLE_BITS-3:0]     j;
   logic [cpt_pkg::SINE_TABLE_BITS-2:0]     idx;
   logic [cpt_pkg::SIN_MAG_W-1:0]           mag;
   logic signed [cpt_pkg::SIN_W-1:0]        pos;

   assign quad = k[cpt_pkg::SINE_TABLE_BITS-1 -: 2];
   assign j    = k[cpt_pkg::SINE_TABLE_BITS-3:0];

   always_comb begin
      // odd quadrants run the quarter wave backwards
      if (quad[0]) begin
         idx = (cpt_pkg::SINE_TABLE_BITS - 1)'(cpt_pkg::QUARTER) - {1'b0, j};
      end else begin
         idx = {1'b0, j};
      end
      // top bit set only at the quarter point itself
      if (idx[cpt_pkg::SINE_TABLE_BITS-2]) begin
         mag = cpt_pkg::SIN_PEAK;
      end else begin
         mag = cpt_pkg::SIN_TABLE[idx[cpt_pkg::SINE_TABLE_BITS-3:0]];
      end
      pos = $signed({1'b0, mag});
      sin = quad[1] ? -pos : pos;
   end

endmodule

### design/cpt_products.sv
// multiplier stage: the four rotation products and the clarke beta product
// depends on cpt_pkg
module cpt_products (
   input  cpt_pkg::lookup_stage_type lkp,
   output cpt_pkg::prod_stage_type   prod
);

   logic signed [cpt_pkg::CLARKE_SUM_W-1:0] clarke_sum;
   logic signed [cpt_pkg::INV_SQRT3_W:0]    inv_sqrt3;

   assign clarke_sum = cpt_pkg::CLARKE_SUM_W'(lkp.a) + (cpt_pkg::CLARKE_SUM_W'(lkp.b) <<< 1);
   assign inv_sqrt3  = $signed({1'b0, cpt_pkg::INV_SQRT3_Q16});

   always_comb begin
      prod.func   = lkp.func;
      prod.a      = lkp.a;
      prod.a_c    = cpt_pkg::PROD_W'(lkp.a) * cpt_pkg::PROD_W'(lkp.cos);
      prod.b_s    = cpt_pkg::PROD_W'(lkp.b) * cpt_pkg::PROD_W'(lkp.sin);
      prod.b_c    = cpt_pkg::PROD_W'(lkp.b) * cpt_pkg::PROD_W'(lkp.cos);
      prod.a_s    = cpt_pkg::PROD_W'(lkp.a) * cpt_pkg::PROD_W'(lkp.sin);
      prod.clarke = cpt_pkg::CLARKE_PROD_W'(clarke_sum) * cpt_pkg::CLARKE_PROD_W'(inv_sqrt3);
   end

endmodule

### design/cpt_combine.sv
// final stage: product sums, round half up, saturation and operation select
// depends on cpt_pkg
module cpt_combine (
   input  cpt_pkg::prod_stage_type prod,
   output cpt_pkg::rsp_stage_type  rsp
);

   logic signed [cpt_pkg::SUM_W-1:0]  park_a_sum;
   logic signed [cpt_pkg::SUM_W-1:0]  park_b_sum;
   logic signed [cpt_pkg::SUM_W-1:0]  inv_a_sum;
   logic signed [cpt_pkg::SUM_W-1:0]  inv_b_sum;
   logic signed [cpt_pkg::SUM_W-1:0]  sel_a_sum;
   logic signed [cpt_pkg::SUM_W-1:0]  sel_b_sum;
   logic signed [cpt_pkg::SUM_W-1:0]  rnd_a;
   logic signed [cpt_pkg::SUM_W-1:0]  rnd_b;
   logic signed [cpt_pkg::WIDE_W-1:0] rot_a_wide;
   logic signed [cpt_pkg::WIDE_W-1:0] rot_b_wide;
   logic signed [cpt_pkg::WIDE_W-1:0] clarke_rnd;
   cpt_pkg::sat_type                  sat_a;
   cpt_pkg::sat_type                  sat_b;
   cpt_pkg::sat_type                  sat_clarke;

   assign park_a_sum = cpt_pkg::SUM_W'(prod.a_c) + cpt_pkg::SUM_W'(prod.b_s);
   assign park_b_sum = cpt_pkg::SUM_W'(prod.b_c) - cpt_pkg::SUM_W'(prod.a_s);
   assign inv_a_sum  = cpt_pkg::SUM_W'(prod.a_c) - cpt_pkg::SUM_W'(prod.b_s);
   assign inv_b_sum  = cpt_pkg::SUM_W'(prod.a_s) + cpt_pkg::SUM_W'(prod.b_c);

   assign sel_a_sum = (prod.func == cpt_pkg::FUNC_PARK) ? park_a_sum : inv_a_sum;
   assign sel_b_sum = (prod.func == cpt_pkg::FUNC_PARK) ? park_b_sum : inv_b_sum;

   // adding half an lsb then an arithmetic shift rounds to nearest, ties toward plus infinity
   assign rnd_a = (sel_a_sum + (cpt_pkg::SUM_W'(1) <<< (cpt_pkg::FRAC_BITS - 1)))
                  >>> cpt_pkg::FRAC_BITS;
   assign rnd_b = (sel_b_sum + (cpt_pkg::SUM_W'(1) <<< (cpt_pkg::FRAC_BITS - 1)))
                  >>> cpt_pkg::FRAC_BITS;
   assign rot_a_wide = cpt_pkg::WIDE_W'(rnd_a);
   assign rot_b_wide = cpt_pkg::WIDE_W'(rnd_b);
   assign clarke_rnd = (cpt_pkg::WIDE_W'(prod.clarke)
                        + (cpt_pkg::WIDE_W'(1) <<< (cpt_pkg::CLARKE_SHIFT - 1)))
                       >>> cpt_pkg::CLARKE_SHIFT;

   assign sat_a      = cpt_pkg::saturate(rot_a_wide);
   assign sat_b      = cpt_pkg::saturate(rot_b_wide);
   assign sat_clarke = cpt_pkg::saturate(clarke_rnd);

   always_comb begin
      case (prod.func)
         cpt_pkg::FUNC_CLARKE: begin
            rsp.out_a     = prod.a;
            rsp.out_b     = sat_clarke.value;
            rsp.saturated = sat_clarke.clipped;
         end
         cpt_pkg::FUNC_PARK, cpt_pkg::FUNC_INV_PARK: begin
            rsp.out_a     = sat_a.value;
            rsp.out_b     = sat_b.value;
            rsp.saturated = sat_a.clipped | sat_b.clipped;
         end
         default: begin
            rsp.out_a     = '0;
            rsp.out_b     = '0;
            rsp.saturated = 1'b0;
         end
      endcase
   end

endmodule

### design/clarke_park_transform.sv
// top level of the clarke / park / inverse park transform unit
// depends on cpt_pkg, cpt_sine_lookup, cpt_products and cpt_combine

// Four-register pipeline (input, sine/cosine lookup, products, result) that
// accepts one transaction per clock unless a full pipeline is held by a low
// rsp_ready, and returns exactly one result per transaction, in order. Each
// passes in_ff, lkp_ff, prod_ff and rsp_ff in turn and is offered from rsp_ff;
// the four 16x16 rotation multipliers are each used once per item. Every stage
// advances independently, so the block keeps taking transactions while a
// finished result waits, until all stages are full. Only the low 16 bits of
// req_angle are used (one turn is 65536 counts); the top 10 of those index a
// 1024-point sine table. func code 3 returns zeros with saturated low.
module clarke_park_transform (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic signed [cpt_pkg::DATA_WIDTH-1:0] req_in_a,
   input  logic signed [cpt_pkg::DATA_WIDTH-1:0] req_in_b,
   input  logic signed [31:0]                   req_angle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cpt_pkg::DATA_WIDTH-1:0] rsp_out_a,
   output logic signed [cpt_pkg::DATA_WIDTH-1:0] rsp_out_b,
   output logic                                 rsp_saturated
);

   cpt_pkg::in_stage_type     in_ff;
   cpt_pkg::lookup_stage_type lkp_ff;
   cpt_pkg::lookup_stage_type lkp_in;
   cpt_pkg::prod_stage_type   prod_ff;
   cpt_pkg::prod_stage_type   prod_in;
   cpt_pkg::rsp_stage_type    rsp_ff;
   cpt_pkg::rsp_stage_type    rsp_in;

   logic in_valid_ff;
   logic lkp_valid_ff;
   logic prod_valid_ff;
   logic rsp_valid_ff;
   logic in_load;
   logic lkp_load;
   logic prod_load;
   logic rsp_load;
   logic [cpt_pkg::SINE_TABLE_BITS-1:0] cos_k;

   // a stage loads when empty or when the stage after it loads too
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign prod_load = !prod_valid_ff || rsp_load;
   assign lkp_load  = !lkp_valid_ff || prod_load;
   assign in_load   = !in_valid_ff || lkp_load;
   assign req_ready = in_load;

   assign cos_k = in_ff.k + cpt_pkg::SINE_TABLE_BITS'(cpt_pkg::QUARTER);

   cpt_sine_lookup u_sin (
      .k   (in_ff.k),
      .sin (lkp_in.sin)
   );

   cpt_sine_lookup u_cos (
      .k   (cos_k),
      .sin (lkp_in.cos)
   );

   assign lkp_in.func = in_ff.func;
   assign lkp_in.a    = in_ff.a;
   assign lkp_in.b    = in_ff.b;

   cpt_products u_products (
      .lkp  (lkp_ff),
      .prod (prod_in)
   );

   cpt_combine u_combine (
      .prod (prod_ff),
      .rsp  (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         lkp_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_valid;
         end
         if (lkp_load) begin
            lkp_valid_ff <= in_valid_ff;
         end
         if (prod_load) begin
            prod_valid_ff <= lkp_valid_ff;
         end
         if (rsp_load) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_ff.func <= req_func;
         in_ff.a    <= req_in_a;
         in_ff.b    <= req_in_b;
         in_ff.k    <= req_angle[15 -: cpt_pkg::SINE_TABLE_BITS];
      end
      if (lkp_load) begin
         lkp_ff <= lkp_in;
      end
      if (prod_load) begin
         prod_ff <= prod_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_a     = rsp_ff.out_a;
   assign rsp_out_b     = rsp_ff.out_b;
   assign rsp_saturated = rsp_ff.saturated;

endmodule
